/* sv/brs_pkg.sv */
// Shared types, pattern ROM and tone lookup for the buzzer rhythm sequencer.
// No dependencies; used by brs_core and buzzer_rhythm_sequencer.
package brs_pkg;

    localparam int unsigned TICK_MS = 10;

    // Pattern numbers at or above this are rejected; also the "no pattern" code.
    localparam logic [2:0] PATTERN_COUNT = 3'd6;
    localparam logic [2:0] ROM_LAST      = 3'd5;

    // Step times in ticks (ms / TICK_MS, rounded down)
    localparam logic [15:0] T_1000 = 16'(1000 / TICK_MS);
    localparam logic [15:0] T_260  = 16'(260 / TICK_MS);
    localparam logic [15:0] T_250  = 16'(250 / TICK_MS);
    localparam logic [15:0] T_150  = 16'(150 / TICK_MS);
    localparam logic [15:0] T_130  = 16'(130 / TICK_MS);
    localparam logic [15:0] T_80   = 16'(80 / TICK_MS);
    localparam logic [15:0] T_50   = 16'(50 / TICK_MS);
    localparam logic [15:0] T_48   = 16'(48 / TICK_MS);
    localparam logic [15:0] T_0    = 16'd0;

    // Configuration register indexes
    localparam logic [2:0] REG_TONE_1 = 3'd0;
    localparam logic [2:0] REG_TONE_2 = 3'd1;
    localparam logic [2:0] REG_TONE_3 = 3'd2;
    localparam logic [2:0] REG_TONE_4 = 3'd3;

    localparam logic [15:0] TONE_1_RESET = 16'd3000;
    localparam logic [15:0] TONE_2_RESET = 16'd2000;
    localparam logic [15:0] TONE_3_RESET = 16'd1500;
    localparam logic [15:0] TONE_4_RESET = 16'd1200;
    localparam logic [15:0] PERIOD_RESET = 16'd1500;

    // Tone selectors held in the ROM
    localparam logic [2:0] TONE_NONE = 3'd0;
    localparam logic [2:0] TONE_1    = 3'd1;
    localparam logic [2:0] TONE_2    = 3'd2;
    localparam logic [2:0] TONE_3    = 3'd3;
    localparam logic [2:0] TONE_4    = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2
    } phase_t;

    typedef logic [3:0][15:0] tone_bank_t;

    typedef struct packed {
        logic [2:0]  tone;
        logic [15:0] on_ticks;
        logic [15:0] off_ticks;
    } rom_step_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  active_pattern;
        logic [1:0]  step_number;
        logic [1:0]  step_total;
        logic [15:0] on_left;
        logic [15:0] off_left;
        logic        out_en;
        logic [15:0] period;
    } seq_state_t;

    function automatic logic [2:0] rom_index(input logic [2:0] pattern);
        rom_index = (pattern > ROM_LAST) ? ROM_LAST : pattern;
    endfunction

    function automatic logic [1:0] rom_count(input logic [2:0] pattern);
        case (rom_index(pattern))
            3'd2:    rom_count = 2'd2;
            3'd3:    rom_count = 2'd3;
            default: rom_count = 2'd1;
        endcase
    endfunction

    function automatic rom_step_t rom_step(input logic [2:0] pattern, input logic [1:0] step);
        rom_step_t s;
        s = '{tone: TONE_NONE, on_ticks: T_0, off_ticks: T_0};
        if (step == 2'd0)
        begin
            case (rom_index(pattern))
                3'd0:    s = '{tone: TONE_2, on_ticks: T_260,  off_ticks: T_0};
                3'd1:    s = '{tone: TONE_2, on_ticks: T_250,  off_ticks: T_50};
                3'd2:    s = '{tone: TONE_2, on_ticks: T_150,  off_ticks: T_50};
                3'd3:    s = '{tone: TONE_2, on_ticks: T_130,  off_ticks: T_48};
                3'd4:    s = '{tone: TONE_2, on_ticks: T_250,  off_ticks: T_0};
                default: s = '{tone: TONE_2, on_ticks: T_1000, off_ticks: T_0};
            endcase
        end
        else if (step == 2'd1)
        begin
            case (rom_index(pattern))
                3'd2:    s = '{tone: TONE_2, on_ticks: T_150, off_ticks: T_80};
                3'd3:    s = '{tone: TONE_2, on_ticks: T_130, off_ticks: T_48};
                default: s = '{tone: TONE_NONE, on_ticks: T_0, off_ticks: T_0};
            endcase
        end
        else if (step == 2'd2)
        begin
            if (rom_index(pattern) == 3'd3)
            begin
                s = '{tone: TONE_2, on_ticks: T_130, off_ticks: T_48};
            end
        end
        return s;
    endfunction

    function automatic logic [15:0] tone_lookup(input tone_bank_t bank, input logic [2:0] tone);
        case (tone)
            TONE_1:  tone_lookup = bank[0];
            TONE_2:  tone_lookup = bank[1];
            TONE_3:  tone_lookup = bank[2];
            TONE_4:  tone_lookup = bank[3];
            default: tone_lookup = 16'd0;
        endcase
    endfunction

endpackage

/* sv/buzzer_rhythm_sequencer.sv */
// Buzzer rhythm sequencer top level: tone registers, sequencer state, output register.
// Depends on brs_pkg and brs_core.
//
//  channel | direction | handshake         | payload
//  s_*     | in        | s_tvalid/s_tready | tuser mode, tdata pattern_number
//  m_*     | out       | m_tvalid/m_tready | tdata buzzer_on, pwm_period, pwm_duty, busy_res
//  cfg_*   | in        | cfg_we            | cfg_index, cfg_data (tone periods)
//
// One beat per cycle while s_tready is high: the state update is a single pass of brs_core
// straight into the state registers, and the status lands in the output register.
// Every input beat gives one output beat, presented in the cycle after acceptance.
// s_tready is low only while the output register is full and m_tready is low.
// Reset (rst_n low, asynchronous) clears state and restores the tone periods.
module buzzer_rhythm_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] pattern_number, [7:3] zero
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] buzzer_on, [16:1] pwm_period,
                                   // [31:17] pwm_duty, [32] busy_res, [39:33] zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    brs_pkg::tone_bank_t tones_reg;
    brs_pkg::seq_state_t state_reg;
    brs_pkg::seq_state_t state_next;
    logic                out_valid_reg;
    logic [39:0]         out_data_reg;
    logic [39:0]         out_data_next;
    logic                accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tones_reg[0] <= brs_pkg::TONE_1_RESET;
            tones_reg[1] <= brs_pkg::TONE_2_RESET;
            tones_reg[2] <= brs_pkg::TONE_3_RESET;
            tones_reg[3] <= brs_pkg::TONE_4_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brs_pkg::REG_TONE_1: tones_reg[0] <= cfg_data;
                brs_pkg::REG_TONE_2: tones_reg[1] <= cfg_data;
                brs_pkg::REG_TONE_3: tones_reg[2] <= cfg_data;
                brs_pkg::REG_TONE_4: tones_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    brs_core u_core (
        .state          (state_reg),
        .mode           (s_tuser),
        .pattern_number (s_tdata[2:0]),
        .tones          (tones_reg),
        .state_next     (state_next)
    );

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = state_next.out_en;
        out_data_next[16:1]  = state_next.period;
        out_data_next[31:17] = state_next.period[15:1];
        out_data_next[32]    = state_next.active_pattern < brs_pkg::PATTERN_COUNT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= brs_pkg::PH_IDLE;
            state_reg.active_pattern <= brs_pkg::PATTERN_COUNT;
            state_reg.step_number    <= 2'd0;
            state_reg.step_total     <= 2'd0;
            state_reg.on_left        <= 16'd0;
            state_reg.off_left       <= 16'd0;
            state_reg.out_en         <= 1'b0;
            state_reg.period         <= brs_pkg::PERIOD_RESET;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Playing implies a pattern is selected
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == brs_pkg::PH_ON || state_reg.phase == brs_pkg::PH_OFF)
        |-> (state_reg.active_pattern < brs_pkg::PATTERN_COUNT))
        else $error("sequencer playing with no pattern selected");

    // Buzzer is silent through the off phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == brs_pkg::PH_OFF) |-> !state_reg.out_en)
        else $error("buzzer enabled during off phase");

    // Step index stays inside the pattern while playing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == brs_pkg::PH_ON || state_reg.phase == brs_pkg::PH_OFF)
        |-> (state_reg.step_number < state_reg.step_total))
        else $error("step number beyond pattern length");

    // An accepted beat always leaves a result waiting in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no result");

endmodule

/* sv/brs_core.sv */
// Next-state logic of the sequencer for one beat (tick or start request).
// Depends on brs_pkg.
module brs_core (
    input  brs_pkg::seq_state_t state,
    input  logic                mode,
    input  logic [2:0]          pattern_number,
    input  brs_pkg::tone_bank_t tones,
    output brs_pkg::seq_state_t state_next
);

    logic [1:0]         step_inc;
    logic [1:0]         load_step_no;
    logic               do_load;
    brs_pkg::rom_step_t step_data;

    assign step_inc = state.step_number + 2'd1;

    always_comb
    begin
        state_next   = state;
        do_load      = 1'b0;
        load_step_no = 2'd0;
        step_data    = '0;
        if (mode)
        begin
            if (pattern_number < brs_pkg::PATTERN_COUNT)
            begin
                state_next.active_pattern = pattern_number;
                state_next.phase          = brs_pkg::PH_IDLE;
            end
        end
        else
        begin
            case (state.phase)
                brs_pkg::PH_IDLE:
                begin
                    if (state.active_pattern < brs_pkg::PATTERN_COUNT)
                    begin
                        state_next.step_number = 2'd0;
                        state_next.step_total  = brs_pkg::rom_count(state.active_pattern);
                        do_load                = 1'b1;
                        load_step_no           = 2'd0;
                    end
                end
                brs_pkg::PH_ON:
                begin
                    if (state.on_left != 16'd0)
                    begin
                        state_next.on_left = state.on_left - 16'd1;
                    end
                    else
                    begin
                        state_next.phase  = brs_pkg::PH_OFF;
                        state_next.out_en = 1'b0;
                    end
                end
                brs_pkg::PH_OFF:
                begin
                    if (state.off_left != 16'd0)
                    begin
                        state_next.off_left = state.off_left - 16'd1;
                    end
                    else if (step_inc < state.step_total)
                    begin
                        state_next.step_number = step_inc;
                        do_load                = 1'b1;
                        load_step_no           = step_inc;
                    end
                    else
                    begin
                        state_next.phase          = brs_pkg::PH_IDLE;
                        state_next.active_pattern = brs_pkg::PATTERN_COUNT;
                        state_next.step_number    = 2'd0;
                        state_next.out_en         = 1'b0;
                    end
                end
                default:
                begin
                    state_next.phase          = brs_pkg::PH_IDLE;
                    state_next.active_pattern = brs_pkg::PATTERN_COUNT;
                end
            endcase
        end

        if (do_load)
        begin
            step_data           = brs_pkg::rom_step(state.active_pattern, load_step_no);
            state_next.on_left  = step_data.on_ticks;
            state_next.off_left = step_data.off_ticks;
            state_next.period   = brs_pkg::tone_lookup(tones, step_data.tone);
            state_next.out_en   = 1'b1;
            state_next.phase    = brs_pkg::PH_ON;
        end
    end

endmodule

/* dv/tb_buzzer_rhythm_sequencer.sv */
// Self-checking testbench for buzzer_rhythm_sequencer: directed and random tick/start
// streams, with a scoreboard class that predicts every status beat.
// Depends on brs_pkg and the buzzer_rhythm_sequencer RTL.
`timescale 1ns / 100ps

module tb_buzzer_rhythm_sequencer;

    localparam bit         MODE_TICK      = 1'b0;
    localparam bit         MODE_START     = 1'b1;
    localparam logic [2:0] REG_UNUSED_LO  = 3'd4;
    localparam logic [2:0] REG_UNUSED_HI  = 3'd7;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         TIMEOUT_NS     = 4_000_000;
    localparam int         PHASE_QUOTA    = 340;

    class tone_seq_scoreboard;
        typedef struct packed {
            logic        buzzer_on;
            logic [15:0] pwm_period;
            logic [14:0] pwm_duty;
            logic        busy;
        } status_t;

        brs_pkg::phase_t ph;
        logic [2:0]  pattern;
        logic [1:0]  step_no;
        logic [1:0]  step_cnt;
        logic [15:0] on_left;
        logic [15:0] off_left;
        logic        sounding;
        logic [15:0] period;
        logic [15:0] tone_reg [4];
        status_t     status_q [$];
        int          errors;
        int          results;

        function new();
            tone_reg[0] = brs_pkg::TONE_1_RESET;
            tone_reg[1] = brs_pkg::TONE_2_RESET;
            tone_reg[2] = brs_pkg::TONE_3_RESET;
            tone_reg[3] = brs_pkg::TONE_4_RESET;
            ph       = brs_pkg::PH_IDLE;
            pattern  = brs_pkg::PATTERN_COUNT;
            step_no  = 2'd0;
            step_cnt = 2'd0;
            on_left  = 16'd0;
            off_left = 16'd0;
            sounding = 1'b0;
            period   = brs_pkg::PERIOD_RESET;
            errors   = 0;
            results  = 0;
        endfunction

        function void write_tone(input logic [2:0] idx, input logic [15:0] val);
            case (idx)
                brs_pkg::REG_TONE_1: tone_reg[0] = val;
                brs_pkg::REG_TONE_2: tone_reg[1] = val;
                brs_pkg::REG_TONE_3: tone_reg[2] = val;
                brs_pkg::REG_TONE_4: tone_reg[3] = val;
                default:    ;
            endcase
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function bit busy();
            return pattern < brs_pkg::PATTERN_COUNT;
        endfunction

        function logic [1:0] step_count(input logic [2:0] p);
            if (p == 3'd2)
                return 2'd2;
            else if (p == 3'd3)
                return 2'd3;
            return 2'd1;
        endfunction

        // Beep times in ms; every step in the table sounds tone two
        function void beep_plan(input logic [2:0] p, input logic [1:0] s,
                                output int on_ms, output int off_ms, output logic [2:0] tone);
            tone   = brs_pkg::TONE_2;
            off_ms = 0;
            case (p)
                3'd0: on_ms = 260;
                3'd1:
                begin
                    on_ms  = 250;
                    off_ms = 50;
                end
                3'd2:
                begin
                    on_ms  = 150;
                    off_ms = (s == 2'd0) ? 50 : 80;
                end
                3'd3:
                begin
                    on_ms  = 130;
                    off_ms = 48;
                end
                3'd4: on_ms = 250;
                default: on_ms = 1000;
            endcase
        endfunction

        function void load_step();
            int         on_ms;
            int         off_ms;
            logic [2:0] tone;
            beep_plan(pattern, step_no, on_ms, off_ms, tone);
            on_left  = 16'(on_ms / brs_pkg::TICK_MS);
            off_left = 16'(off_ms / brs_pkg::TICK_MS);
            period   = (tone >= brs_pkg::TONE_1 && tone <= brs_pkg::TONE_4)
                       ? tone_reg[tone - brs_pkg::TONE_1] : 16'd0;
            sounding = 1'b1;
            ph       = brs_pkg::PH_ON;
        endfunction

        // Advances the prediction by one accepted beat; returns 0 if the beat had no effect
        function bit note_beat(input bit mode, input logic [2:0] num);
            status_t st;
            bit      effect;
            effect = mode ? (num < brs_pkg::PATTERN_COUNT)
                          : (ph != brs_pkg::PH_IDLE || pattern < brs_pkg::PATTERN_COUNT);
            if (mode)
            begin
                if (num < brs_pkg::PATTERN_COUNT)
                begin
                    pattern = num;
                    ph      = brs_pkg::PH_IDLE;
                end
            end
            else
            begin
                case (ph)
                    brs_pkg::PH_IDLE:
                    begin
                        if (pattern < brs_pkg::PATTERN_COUNT)
                        begin
                            step_no  = 2'd0;
                            step_cnt = step_count(pattern);
                            load_step();
                        end
                    end
                    brs_pkg::PH_ON:
                    begin
                        if (on_left != 16'd0)
                            on_left--;
                        else
                        begin
                            ph       = brs_pkg::PH_OFF;
                            sounding = 1'b0;
                        end
                    end
                    brs_pkg::PH_OFF:
                    begin
                        if (off_left != 16'd0)
                            off_left--;
                        else
                        begin
                            step_no = step_no + 2'd1;
                            if (step_no < step_cnt)
                                load_step();
                            else
                            begin
                                ph       = brs_pkg::PH_IDLE;
                                pattern  = brs_pkg::PATTERN_COUNT;
                                step_no  = 2'd0;
                                sounding = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        ph      = brs_pkg::PH_IDLE;
                        pattern = brs_pkg::PATTERN_COUNT;
                    end
                endcase
            end
            st.buzzer_on  = sounding;
            st.pwm_period = period;
            st.pwm_duty   = period[15:1];
            st.busy       = (pattern < brs_pkg::PATTERN_COUNT);
            status_q.push_back(st);
            return effect;
        endfunction

        function void report(input string field, input logic [15:0] want, input logic [15:0] got);
            errors++;
            $display("%0t ns: mismatch on %s, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_beat(input logic [39:0] d);
            status_t want;
            results++;
            if (status_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result beat %h, expected none", $time, d);
                return;
            end
            want = status_q.pop_front();
            if (d[0] !== want.buzzer_on)
                report("buzzer_on", 16'(want.buzzer_on), 16'(d[0]));
            if (d[16:1] !== want.pwm_period)
                report("pwm_period", want.pwm_period, d[16:1]);
            if (d[31:17] !== want.pwm_duty)
                report("pwm_duty", 16'(want.pwm_duty), 16'(d[31:17]));
            if (d[32] !== want.busy)
                report("busy_res", 16'(want.busy), 16'(d[32]));
            if (d[39:33] !== 7'd0)
                report("padding", 16'd0, 16'(d[39:33]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;    // [2:0] pattern_number, [7:3] zero
    logic        s_tuser = 1'b0;    // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [0] buzzer_on, [16:1] pwm_period, [31:17] pwm_duty,
                                    // [32] busy_res, [39:33] zero
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data = 16'd0;

    tone_seq_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int holds_done = 0;
    int beats_sent = 0;
    int effective = 0;
    int tone_settings = 0;

    buzzer_rhythm_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: random back-pressure, plus one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                m_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null && m_tvalid && m_tready)
            sb.check_beat(m_tdata);
    end

    task automatic send_beat(input bit mode, input logic [2:0] num);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'd0, num};
        do
            @(posedge clk);
        while (!s_tready);
        if (sb.note_beat(mode, num))
            effective++;
        beats_sent++;
    endtask

    task automatic tick();
        send_beat(MODE_TICK, 3'($urandom_range(7)));
    endtask

    // Stop sending and let every expected beat come back
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_tones(input logic [15:0] t1, input logic [15:0] t2,
                                 input logic [15:0] t3, input logic [15:0] t4);
        logic [2:0]  idx [5];
        logic [15:0] val [5];
        idx = '{3'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                brs_pkg::REG_TONE_1, brs_pkg::REG_TONE_2, brs_pkg::REG_TONE_3,
                brs_pkg::REG_TONE_4};
        val = '{16'($urandom), t1, t2, t3, t4};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_tone(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        tone_settings++;
    endtask

    // Mostly full or cut-short plays of valid patterns, with some stray beats mixed in
    task automatic run_sequences(input int quota);
        int base;
        int pick;
        base = effective;
        while (effective - base < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_beat(MODE_START, 3'($urandom_range(7, 6)));
            else if (pick < 14)
                tick();
            else
            begin
                send_beat(MODE_START, 3'($urandom_range(5, 0)));
                if ($urandom_range(99) < 65)
                begin
                    while (sb.busy())
                        tick();
                    repeat ($urandom_range(2)) tick();
                end
                else
                    repeat ($urandom_range(30)) tick();
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejected numbers, idle ticks, reselect and restart mid-play
        tick();
        send_beat(MODE_START, 3'd7);
        send_beat(MODE_START, 3'd6);
        tick();
        send_beat(MODE_START, 3'd0);
        send_beat(MODE_START, 3'd5);
        tick();
        tick();
        send_beat(MODE_START, 3'd3);
        tick();
        tick();
        send_beat(MODE_START, 3'd1);
        tick();
        send_beat(MODE_START, 3'd4);
        tick();
        send_beat(MODE_START, 3'd2);
        tick();
        send_beat(MODE_START, 3'd6);
        send_beat(MODE_TICK, 3'd7);
        send_beat(MODE_TICK, 3'd0);
        settle();

        program_tones(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        tx_idle_pct = 12;
        rx_idle_pct = 63;
        run_sequences(PHASE_QUOTA);
        settle();

        program_tones(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        tx_idle_pct = 63;
        rx_idle_pct = 12;
        run_sequences(PHASE_QUOTA);
        settle();

        program_tones(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        run_sequences(PHASE_QUOTA);
        settle();

        $display("Run covered %0d input beats (%0d changing state), %0d status beats checked,",
                 beats_sent, effective, sb.results);
        $display("%0d tone register settings, %0d long output holds, %0d mismatches.",
                 tone_settings, holds_done, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("buzzer_rhythm_sequencer verification clean");
        else
            $display("buzzer_rhythm_sequencer verification failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d status beats outstanding", sb.pending());
        $display("buzzer_rhythm_sequencer verification failed");
        $finish;
    end

endmodule
